### rtl/core/wsd_pkg.sv
package wsd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned OPCODE_W = 4;
   localparam int unsigned REPLY_W  = 2;
   localparam int unsigned STATUS_W = 2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PROTO  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LONG   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_CLOSED = 2'd3;

   // reply requests
   localparam logic [REPLY_W-1:0] REPLY_NONE  = 2'd0;
   localparam logic [REPLY_W-1:0] REPLY_PONG  = 2'd1;
   localparam logic [REPLY_W-1:0] REPLY_CLOSE = 2'd2;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_CONT  = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_TEXT  = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_CLOSE = 4'd8;
   localparam logic [OPCODE_W-1:0] OP_PING  = 4'd9;
   localparam logic [OPCODE_W-1:0] OP_PONG  = 4'd10;

   // header fields
   localparam logic [BYTE_W-1:0] HDR_RSV_MASK  = 8'h70;
   localparam logic [6:0]        LEN_EXT16     = 7'd126;
   localparam logic [6:0]        LEN_EXT64     = 7'd127;
   localparam logic [LEN_W-1:0]  CTRL_MAX_LEN  = 16'd125;

   // register map
   localparam int unsigned        CSR_ADDR_W      = 3;
   localparam int unsigned        CSR_DATA_W      = 32;
   localparam logic               CSR_IDX_LIMIT   = 1'b0;
   localparam logic [LEN_W-1:0]   LIMIT_RESET     = 16'd4096;

   typedef struct packed {
      logic [BYTE_W-1:0]   payload_byte;
      logic                payload_valid;
      logic                payload_is_control;
      logic [LEN_W-1:0]    write_offset;
      logic                frame_end;
      logic                message_end;
      logic [LEN_W-1:0]    message_length;
      logic [REPLY_W-1:0]  reply_action;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

### rtl/core/wsd_req_if.sv
interface wsd_req_if import wsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/wsd_rsp_if.sv
interface wsd_rsp_if import wsd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   payload_byte;
   logic                payload_valid;
   logic                payload_is_control;
   logic [LEN_W-1:0]    write_offset;
   logic                frame_end;
   logic                message_end;
   logic [LEN_W-1:0]    message_length;
   logic [REPLY_W-1:0]  reply_action;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, output payload_byte, output payload_valid, output payload_is_control,
      output write_offset, output frame_end, output message_end, output message_length,
      output reply_action, output status, input ready
   );
   modport sink (
      input valid, input payload_byte, input payload_valid, input payload_is_control,
      input write_offset, input frame_end, input message_end, input message_length,
      input reply_action, input status, output ready
   );
endinterface

### rtl/core/websocket_frame_deframer_unit.sv
// The response beat for an accepted request beat is registered: it appears in the cycle after the accept.
// Throughput: one byte per cycle; the parser state and the output register
// both update at the accepting edge, so the only stall is a full output register.
// Reset (synchronous, active high): parser waits for a first header byte,
// no message open, status ok, message limit 4096, output register empty.
module websocket_frame_deframer_unit import wsd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wsd_req_if.sink               req,
   wsd_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // parser phases
   localparam logic [2:0] PH_HDR0  = 3'd0;
   localparam logic [2:0] PH_HDR1  = 3'd1;
   localparam logic [2:0] PH_EXTHI = 3'd2;
   localparam logic [2:0] PH_EXTLO = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_STOP  = 3'd5;

   // parser state
   logic [2:0]          phase_ff,     phase_in;
   logic                final_ff,     final_in;
   logic [OPCODE_W-1:0] opcode_ff,    opcode_in;
   logic [LEN_W-1:0]    remaining_ff, remaining_in;
   logic [LEN_W-1:0]    offset_ff,    offset_in;
   logic [LEN_W-1:0]    used_ff,      used_in;
   logic                more_ff,      more_in;
   logic [STATUS_W-1:0] stop_ff,      stop_in;

   // configuration
   logic [LEN_W-1:0]    limit_ff;

   // output register
   logic                rsp_valid_ff;
   result_type          rsp_data_ff;
   result_type          res;

   logic                accept;
   logic                csr_write;
   logic [BYTE_W-1:0]   b;

   // frame start decisions, shared by the short and the 16-bit length paths
   logic [LEN_W-1:0]    len_sel;
   logic                is_ctrl;
   logic                ctrl_bad;
   logic                data_bad;
   logic [LEN_W-1:0]    used_base;
   logic [LEN_W:0]      used_sum;
   logic                too_long;

   // frame completion
   logic                finish;
   logic [LEN_W-1:0]    finish_used;

   //------------------------------------------------------------------
   // Configuration port: zero-wait APB, one register
   //------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_IDX_LIMIT)) begin
         limit_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_LIMIT) begin
         csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, limit_ff};
      end
   end

   //------------------------------------------------------------------
   // Handshake: take a new beat whenever the output register is free or
   // is being drained in this same cycle.
   //------------------------------------------------------------------
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;

   //------------------------------------------------------------------
   // Frame start checks. Length comes from the second header byte or
   // from the high byte held over from the previous beat plus this one.
   //------------------------------------------------------------------
   always_comb begin
      if (phase_ff == PH_EXTLO) begin
         len_sel = {remaining_ff[15:8], b};
      end else begin
         len_sel = {{(LEN_W-7){1'b0}}, b[6:0]};
      end
      is_ctrl  = opcode_ff[3];
      ctrl_bad = !final_ff || (len_sel > CTRL_MAX_LEN) || (opcode_ff > OP_PONG)
                 || ((opcode_ff == OP_CLOSE) && (len_sel == 16'd1));
      if (opcode_ff == OP_TEXT) begin
         data_bad  = more_ff;
         used_base = '0;
      end else begin
         data_bad  = (opcode_ff != OP_CONT) || !more_ff;
         used_base = used_ff;
      end
      // a 17-bit sum covers both "already over" and "this frame pushes over"
      used_sum = {1'b0, used_base} + {1'b0, len_sel};
      too_long = used_sum > {1'b0, limit_ff};
   end

   //------------------------------------------------------------------
   // Byte step: next parser state and this beat's result
   //------------------------------------------------------------------
   always_comb begin
      phase_in     = phase_ff;
      final_in     = final_ff;
      opcode_in    = opcode_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      used_in      = used_ff;
      more_in      = more_ff;
      stop_in      = stop_ff;
      res          = '0;
      finish       = 1'b0;
      finish_used  = used_ff;

      if (stop_ff != STATUS_OK) begin
         // stopped: ignore the byte, repeat the stop code
         phase_in = PH_STOP;
      end else begin
         unique case (phase_ff) inside
            PH_HDR0: begin
               if ((b & HDR_RSV_MASK) != '0) begin
                  stop_in  = STATUS_PROTO;
                  phase_in = PH_STOP;
               end else begin
                  final_in  = b[7];
                  opcode_in = b[OPCODE_W-1:0];
                  phase_in  = PH_HDR1;
               end
            end
            PH_HDR1, PH_EXTLO: begin
               if ((phase_ff == PH_HDR1) && b[7]) begin
                  // masked frame from the server side
                  stop_in  = STATUS_PROTO;
                  phase_in = PH_STOP;
               end else if ((phase_ff == PH_HDR1) && (b[6:0] == LEN_EXT16)) begin
                  phase_in = PH_EXTHI;
               end else if ((phase_ff == PH_HDR1) && (b[6:0] == LEN_EXT64)) begin
                  stop_in  = STATUS_LONG;
                  phase_in = PH_STOP;
               end else if (is_ctrl && ctrl_bad) begin
                  stop_in  = STATUS_PROTO;
                  phase_in = PH_STOP;
               end else if (!is_ctrl && data_bad) begin
                  stop_in  = STATUS_PROTO;
                  phase_in = PH_STOP;
               end else if (!is_ctrl && too_long) begin
                  stop_in  = STATUS_LONG;
                  phase_in = PH_STOP;
               end else begin
                  if (!is_ctrl) begin
                     used_in = used_base;
                  end
                  remaining_in = len_sel;
                  offset_in    = '0;
                  if (len_sel == '0) begin
                     // empty frame ends on its last header byte
                     finish      = 1'b1;
                     finish_used = used_base;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_EXTHI: begin
               remaining_in = {b, 8'h00};
               phase_in     = PH_EXTLO;
            end
            PH_DATA: begin
               res.payload_byte  = b;
               res.payload_valid = 1'b1;
               if (is_ctrl) begin
                  res.payload_is_control = 1'b1;
                  res.write_offset       = offset_ff;
               end else begin
                  res.write_offset = used_ff;
                  used_in          = used_ff + 16'd1;
               end
               offset_in    = offset_ff + 16'd1;
               remaining_in = remaining_ff - 16'd1;
               if (remaining_ff == 16'd1) begin
                  finish      = 1'b1;
                  finish_used = used_ff + 16'd1;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase

         // frame completion: reply requests for control, message close-out for data
         if (finish) begin
            res.frame_end = 1'b1;
            phase_in      = PH_HDR0;
            if (is_ctrl) begin
               if (opcode_ff == OP_PING) begin
                  res.reply_action = REPLY_PONG;
               end else if (opcode_ff == OP_CLOSE) begin
                  res.reply_action = REPLY_CLOSE;
                  stop_in          = STATUS_CLOSED;
                  phase_in         = PH_STOP;
               end
            end else begin
               more_in = !final_ff;
               if (final_ff) begin
                  res.message_end    = 1'b1;
                  res.message_length = finish_used;
                  used_in            = '0;
               end
            end
         end
      end

      res.status = stop_in;
   end

   //------------------------------------------------------------------
   // State and output registers
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         final_ff     <= 1'b0;
         opcode_ff    <= '0;
         remaining_ff <= '0;
         offset_ff    <= '0;
         used_ff      <= '0;
         more_ff      <= 1'b0;
         stop_ff      <= STATUS_OK;
      end else if (accept) begin
         phase_ff     <= phase_in;
         final_ff     <= final_in;
         opcode_ff    <= opcode_in;
         remaining_ff <= remaining_in;
         offset_ff    <= offset_in;
         used_ff      <= used_in;
         more_ff      <= more_in;
         stop_ff      <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the payload while a beat waits downstream
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.payload_byte       = rsp_data_ff.payload_byte;
   assign rsp.payload_valid      = rsp_data_ff.payload_valid;
   assign rsp.payload_is_control = rsp_data_ff.payload_is_control;
   assign rsp.write_offset       = rsp_data_ff.write_offset;
   assign rsp.frame_end          = rsp_data_ff.frame_end;
   assign rsp.message_end        = rsp_data_ff.message_end;
   assign rsp.message_length     = rsp_data_ff.message_length;
   assign rsp.reply_action       = rsp_data_ff.reply_action;
   assign rsp.status             = rsp_data_ff.status;

endmodule

### test/tb.sv
module tb;
   import wsd_pkg::*;

   // Parser phases of the byte-level frame predictor.
   typedef enum logic [2:0] {
      AWAIT_HDR0,
      AWAIT_HDR1,
      AWAIT_EXT_HI,
      AWAIT_EXT_LO,
      IN_PAYLOAD,
      HALTED
   } parse_phase_type;

   // Ways of ending the run's traffic.  Any of them stops the block for good, and
   // reset comes only once, so each run draws exactly one of them.
   typedef enum int {
      BAD_RSV,
      BAD_MASK,
      LEN_64,
      CTRL_FRAGMENT,
      CTRL_TOO_LONG,
      CLOSE_LEN_ONE,
      CTRL_OP_RESERVED,
      DATA_OP_RESERVED,
      TEXT_IN_MESSAGE,
      CONT_NO_MESSAGE,
      OVERSIZE,
      LIMIT_LOWERED,
      PEER_CLOSE
   } stop_cause_type;

   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * CSR_IDX_LIMIT);

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   wsd_req_if req ();
   wsd_rsp_if rsp ();

   websocket_frame_deframer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predicted deframer state, mirrored from reset.
   parse_phase_type       phase         = AWAIT_HDR0;
   logic                  fin_seen      = 1'b0;
   logic [OPCODE_W-1:0]   opcode_seen   = OP_CONT;
   logic [LEN_W-1:0]      bytes_left    = '0;
   logic [LEN_W-1:0]      frame_pos     = '0;
   logic [LEN_W-1:0]      message_fill  = '0;
   logic                  message_open  = 1'b0;
   logic [STATUS_W-1:0]   stop_code     = STATUS_OK;
   logic [LEN_W-1:0]      limit_setting = LIMIT_RESET;
   result_type            beat_out;

   // Expected response beats, oldest first.
   result_type            expected_results[$];

   bit                    req_gaps_on   = 1'b1;
   bit                    rsp_stalls_on = 1'b1;
   int unsigned           items_sent    = 0;
   int unsigned           mismatch_count = 0;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Latch a stop code: from here on every beat only repeats it.
   function automatic void stop_parsing(input logic [STATUS_W-1:0] code);
      stop_code       = code;
      phase           = AWAIT_HDR0;
      phase           = HALTED;
      beat_out.status = code;
   endfunction

   // Close the current frame; control frames may ask for a reply, a final data
   // fragment closes the message and reports its length.
   function automatic void end_of_frame();
      beat_out.frame_end = 1'b1;
      phase = AWAIT_HDR0;
      if (opcode_seen[3]) begin
         if (opcode_seen == OP_PING) begin
            beat_out.reply_action = REPLY_PONG;
         end else if (opcode_seen == OP_CLOSE) begin
            beat_out.reply_action = REPLY_CLOSE;
            stop_parsing(STATUS_CLOSED);
         end
      end else begin
         message_open = !fin_seen;
         if (fin_seen) begin
            beat_out.message_end    = 1'b1;
            beat_out.message_length = message_fill;
            message_fill            = '0;
         end
      end
   endfunction

   // Vet the frame once its length is known, then enter the payload or close an
   // empty frame straight away.
   function automatic void start_of_frame(input logic [LEN_W-1:0] len);
      if (opcode_seen[3]) begin
         if (!fin_seen || len > CTRL_MAX_LEN || opcode_seen > OP_PONG ||
             (opcode_seen == OP_CLOSE && len == 1)) begin
            stop_parsing(STATUS_PROTO);
            return;
         end
      end else begin
         if (opcode_seen == OP_TEXT) begin
            if (message_open) begin
               stop_parsing(STATUS_PROTO);
               return;
            end
            message_fill = '0;
         end else if (opcode_seen != OP_CONT || !message_open) begin
            stop_parsing(STATUS_PROTO);
            return;
         end
         // a limit lowered under the bytes already held also lands here
         if (message_fill > limit_setting || len > limit_setting - message_fill) begin
            stop_parsing(STATUS_LONG);
            return;
         end
      end
      bytes_left = len;
      frame_pos  = '0;
      if (len == 0) end_of_frame();
      else phase = IN_PAYLOAD;
   endfunction

   // Expected response beat for one received byte.
   function automatic result_type deframe(input logic [BYTE_W-1:0] b);
      beat_out = '0;
      if (stop_code != STATUS_OK) begin
         beat_out.status = stop_code;
         return beat_out;
      end
      case (phase)
         AWAIT_HDR0: begin
            if ((b & HDR_RSV_MASK) != 0) begin
               stop_parsing(STATUS_PROTO);
            end else begin
               fin_seen    = b[7];
               opcode_seen = b[OPCODE_W-1:0];
               phase       = AWAIT_HDR1;
            end
         end
         AWAIT_HDR1: begin
            if (b[7]) stop_parsing(STATUS_PROTO);
            else if (b[6:0] == LEN_EXT16) phase = AWAIT_EXT_HI;
            else if (b[6:0] == LEN_EXT64) stop_parsing(STATUS_LONG);
            else start_of_frame(LEN_W'(b[6:0]));
         end
         AWAIT_EXT_HI: begin
            bytes_left = {b, 8'h00};
            phase      = AWAIT_EXT_LO;
         end
         AWAIT_EXT_LO: begin
            start_of_frame({bytes_left[15:8], b});
         end
         IN_PAYLOAD: begin
            beat_out.payload_byte  = b;
            beat_out.payload_valid = 1'b1;
            if (opcode_seen[3]) begin
               beat_out.payload_is_control = 1'b1;
               beat_out.write_offset       = frame_pos;
            end else begin
               beat_out.write_offset = message_fill;
               message_fill          = message_fill + 1'b1;
            end
            frame_pos  = frame_pos + 1'b1;
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) end_of_frame();
         end
         default: phase = AWAIT_HDR0;
      endcase
      beat_out.status = stop_code;
      return beat_out;
   endfunction

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("tb: mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic compare_field(input string name, input int unsigned got,
                                input int unsigned want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // Response side: hold ready low for a drawn number of cycles, then take the
   // next beat and check it against the oldest expectation.
   initial begin : response_checker
      int unsigned stall;
      result_type  want;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = rsp_stalls_on ? $urandom_range(0, 3) : 0;
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (reset !== 1'b0 || rsp.valid !== 1'b1);
         if (expected_results.size() == 0) begin
            report_mismatch("response beat with nothing expected");
         end else begin
            want = expected_results.pop_front();
            compare_field("payload_byte", rsp.payload_byte, want.payload_byte);
            compare_field("payload_valid", rsp.payload_valid, want.payload_valid);
            compare_field("payload_is_control", rsp.payload_is_control,
                          want.payload_is_control);
            compare_field("write_offset", rsp.write_offset, want.write_offset);
            compare_field("frame_end", rsp.frame_end, want.frame_end);
            compare_field("message_end", rsp.message_end, want.message_end);
            compare_field("message_length", rsp.message_length, want.message_length);
            compare_field("reply_action", rsp.reply_action, want.reply_action);
            compare_field("status", rsp.status, want.status);
         end
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers; each is entered and left at a falling edge
   // ---------------------------------------------------------------------------

   // Offer one byte after a drawn gap and predict its beat once it is taken.
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid   <= 1'b1;
      req.rx_byte <= value;
      do @(posedge clock); while (req.ready !== 1'b1);
      expected_results.push_back(deframe(value));
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected beat has come back.
   task automatic drain();
      req.valid <= 1'b0;
      do @(negedge clock); while (expected_results.size() != 0);
   endtask

   task automatic csr_access(input bit is_write, input logic [CSR_DATA_W-1:0] wdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (is_write) limit_setting = wdata[LEN_W-1:0];
      else compare_field("message_limit readback", csr_prdata[LEN_W-1:0], limit_setting);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write the limit only with the block idle, then read it back.
   task automatic set_message_limit(input logic [LEN_W-1:0] value);
      drain();
      csr_access(1'b1, CSR_DATA_W'(value));
      csr_access(1'b0, '0);
   endtask

   task automatic send_header(input logic fin, input logic [OPCODE_W-1:0] op,
                              input logic [LEN_W-1:0] len, input bit long_form);
      send_byte({fin, 3'b000, op});
      if (long_form || len > CTRL_MAX_LEN) begin
         send_byte({1'b0, LEN_EXT16});
         send_byte(len[15:8]);
         send_byte(len[7:0]);
      end else begin
         send_byte({1'b0, len[6:0]});
      end
   endtask

   task automatic send_frame(input logic fin, input logic [OPCODE_W-1:0] op,
                             input logic [LEN_W-1:0] len, input bit long_form);
      int k;
      send_header(fin, op, len, long_form);
      for (k = 0; k < int'(len); k++) send_byte(BYTE_W'($urandom));
   endtask

   // Random ping or pong, now and then at the largest control length.
   task automatic send_control();
      logic [OPCODE_W-1:0] op;
      int                  len;
      op  = $urandom_range(0, 1) ? OP_PING : OP_PONG;
      len = ($urandom_range(0, 15) == 0) ? int'(CTRL_MAX_LEN) : $urandom_range(0, 8);
      send_frame(1'b1, op, len, $urandom_range(0, 7) == 0);
   endtask

   // Well-formed text message of one to three fragments that fits the limit,
   // with control frames dropped in between now and then.
   task automatic send_message(input int max_piece);
      int pieces, room, cap, len, k;
      pieces = $urandom_range(1, 3);
      room   = limit_setting;
      cap    = ($urandom_range(0, 9) == 0) ? max_piece : 16;
      for (k = 0; k < pieces; k++) begin
         if ($urandom_range(0, 3) == 0) send_control();
         if (cap < room) len = $urandom_range(0, cap);
         else len = ($urandom_range(0, 7) == 0) ? room : $urandom_range(0, room);
         send_frame(k == pieces - 1, (k == 0) ? OP_TEXT : OP_CONT, len,
                    $urandom_range(0, 7) == 0);
         room -= len;
      end
      if ($urandom_range(0, 5) == 0) send_control();
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   task automatic test_directed_frames();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      // final text frame carrying both byte extremes
      send_header(1'b1, OP_TEXT, 2, 1'b0);
      send_byte(8'h00);
      send_byte(8'hff);
      // empty final text frame ends frame and message on its length byte
      send_header(1'b1, OP_TEXT, 0, 1'b0);
      // empty ping asks for a pong at once
      send_header(1'b1, OP_PING, 0, 1'b0);
      // fragmented message with control frames between the fragments
      send_frame(1'b0, OP_TEXT, 1, 1'b0);
      send_frame(1'b1, OP_PING, 1, 1'b0);
      send_header(1'b1, OP_PONG, 0, 1'b0);
      send_frame(1'b1, OP_CONT, 2, 1'b1);   // extended form for a short length
      drain();
   endtask

   task automatic test_random_traffic(input int unsigned n_items, input int max_piece);
      int unsigned first;
      first = items_sent;
      while (items_sent - first < n_items) begin
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         send_message(max_piece);
         // let the pipe run dry now and then before going on
         if ($urandom_range(0, 15) == 0) drain();
      end
      drain();
   endtask

   task automatic test_zero_limit();
      set_message_limit('0);
      test_random_traffic(80, 16);
   endtask

   // Top limit: one long frame with both extended length bytes in use, sent with
   // no idling, then random traffic with large pieces.
   task automatic test_top_limit();
      set_message_limit('1);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      send_frame(1'b1, OP_TEXT, 16'd300, 1'b1);
      drain();
      test_random_traffic(60, 300);
   endtask

   task automatic test_random_limit();
      set_message_limit($urandom_range(1, 400));
      test_random_traffic(450, 400);
   endtask

   // Finish with one stopping condition, then check that later bytes are ignored.
   task automatic test_stop_condition();
      stop_cause_type cause;
      int             used;
      cause         = stop_cause_type'($urandom_range(0, int'(PEER_CLOSE)));
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      case (cause)
         BAD_RSV: begin
            send_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
         end
         BAD_MASK: begin
            send_byte({1'b1, 3'b000, OP_TEXT});
            send_byte({1'b1, 7'($urandom)});
         end
         LEN_64: begin
            send_byte({1'b1, 3'b000, OP_TEXT});
            send_byte({1'b0, LEN_EXT64});
         end
         CTRL_FRAGMENT: begin
            send_header(1'b0, OP_PING, $urandom_range(0, 125), $urandom_range(0, 1));
         end
         CTRL_TOO_LONG: begin
            send_header(1'b1, $urandom_range(0, 1) ? OP_PING : OP_CLOSE,
                        $urandom_range(int'(CTRL_MAX_LEN) + 1, 65535), 1'b1);
         end
         CLOSE_LEN_ONE: begin
            send_header(1'b1, OP_CLOSE, 1, $urandom_range(0, 1));
         end
         CTRL_OP_RESERVED: begin
            send_header(1'b1, 4'($urandom_range(int'(OP_PONG) + 1, 15)),
                        $urandom_range(0, 125), 1'b0);
         end
         DATA_OP_RESERVED: begin
            send_header($urandom_range(0, 1),
                        4'($urandom_range(int'(OP_TEXT) + 1, int'(OP_CLOSE) - 1)),
                        $urandom_range(0, 20), 1'b0);
         end
         TEXT_IN_MESSAGE: begin
            send_frame(1'b0, OP_TEXT,
                       $urandom_range(0, (limit_setting < 5) ? limit_setting : 5), 1'b0);
            send_header(1'b1, OP_TEXT, 0, 1'b0);
         end
         CONT_NO_MESSAGE: begin
            send_header($urandom_range(0, 1), OP_CONT, $urandom_range(0, 20), 1'b0);
         end
         OVERSIZE: begin
            set_message_limit($urandom_range(0, 200));
            send_header(1'b1, OP_TEXT, limit_setting + $urandom_range(1, 60), 1'b0);
         end
         LIMIT_LOWERED: begin
            set_message_limit(100);
            used = $urandom_range(1, 100);
            send_frame(1'b0, OP_TEXT, used, 1'b0);
            set_message_limit($urandom_range(0, used - 1));
            send_header(1'b1, OP_CONT, $urandom_range(0, 5), 1'b0);
         end
         default: begin
            send_frame(1'b1, OP_CLOSE, $urandom_range(0, 1) ? 0 : $urandom_range(2, 125),
                       $urandom_range(0, 1));
         end
      endcase
      repeat (12) send_byte(BYTE_W'($urandom));
      drain();
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.rx_byte = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_access(1'b0, '0);   // reset value of the limit
      test_directed_frames();
      test_random_traffic(400, 300);
      test_zero_limit();
      test_top_limit();
      test_random_limit();
      test_stop_condition();

      // wait before the verdict so that a stray beat is still caught
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Hang guard.
   initial begin
      #5000000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
